>>> src/differential_drive_odometry_top_assert.svh
// Assertion macros for the odometry block.
// Each check is sampled on the rising edge of clk_i and is held off while rst_ni is low.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define DDO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("odometry assertion failed");
`define DDO_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define DDO_ASSERT(lbl, prop)
`define DDO_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

>>> src/ddo_pkg.sv
`default_nettype none

package ddo_pkg;

  // Field and bus widths.
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned IN_DATA_W = 5 * FIELD_W;
  localparam int unsigned OUT_DATA_W = 6 * FIELD_W;
  localparam int unsigned CFG_IDX_W = 2;
  // Dividend magnitude: a 33-bit difference times one million fits in 53 bits.
  localparam int unsigned NUM_W     = 53;
  localparam int unsigned DIFF_W    = FIELD_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [FIELD_W-1:0] TRACK_WIDTH_RST = 32'd65536;
  localparam logic [FIELD_W-1:0] TIMEOUT_RST     = 32'd300000;

  // Microseconds per second, applied to position deltas.
  localparam logic [19:0] SCALE_US = 20'd1000000;

  // Saturation limits of signed Q16.16.
  localparam logic [FIELD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] Q_MIN = 32'h8000_0000;

  // Divisions carried out for one item, in order.
  typedef enum logic [2:0] {
    OP_EST_LEFT,
    OP_EST_RIGHT,
    OP_ANG_SPEED,
    OP_HEADING,
    OP_EST_ANG
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_WAIT,
    ST_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic prep;
    logic div_start;
    logic wb;
    logic load_out;
    op_e  op;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/ddo_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, with signed saturation.
module ddo_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ddo_pkg::NUM_W-1:0]     num_i,
  input  wire logic                          neg_i,
  input  wire logic [ddo_pkg::FIELD_W-1:0]   den_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [ddo_pkg::FIELD_W-1:0]        quo_o
);

  localparam int unsigned W    = ddo_pkg::FIELD_W;

  logic               busy_q, fin_q, sat_q, neg_q;
  logic [4:0]         cnt_q;
  logic [W-1:0]       den_q, rem_q, quo_q;
  logic [W-1:0]       hi_ext;
  logic               ovf, zero;
  logic [W:0]         rem_sh, rem_sub;
  logic               ge;
  logic [W-1:0]       neg_q_val;

  // A quotient of 2^32 or more saturates whatever its sign.
  assign hi_ext = W'(num_i[ddo_pkg::NUM_W-1:W]);
  assign ovf    = hi_ext >= den_i;
  assign zero   = num_i == '0;

  // One restoring step.
  assign rem_sh  = {rem_q, quo_q[W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        if (zero || ovf) begin
          fin_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 5'd31;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      neg_q <= neg_i;
      sat_q <= ovf && !zero;
      rem_q <= hi_ext;
      quo_q <= zero ? '0 : num_i[W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  // Sign and saturation of the unsigned quotient.
  assign neg_q_val = W'(0) - quo_q;

  always_comb begin
    if (sat_q) begin
      quo_o = neg_q ? ddo_pkg::Q_MIN : ddo_pkg::Q_MAX;
    end else if (neg_q) begin
      quo_o = (quo_q > ddo_pkg::Q_MIN) ? ddo_pkg::Q_MIN : neg_q_val;
    end else begin
      quo_o = (quo_q > ddo_pkg::Q_MAX) ? ddo_pkg::Q_MAX : quo_q;
    end
  end

  assign busy_o = busy_q;
  assign done_o = fin_q;

endmodule

`default_nettype wire

>>> src/ddo_datapath.sv
`default_nettype none

// Input, side state, configuration, operand selection, divider and output register.
module ddo_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ddo_pkg::ctrl_cmd_t                cmd_i,
  output ddo_pkg::dp_status_t                    status_o,
  input  wire logic [ddo_pkg::IN_DATA_W-1:0]     in_data_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ddo_pkg::FIELD_W-1:0]       cfg_data_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [ddo_pkg::OUT_DATA_W-1:0]         out_data_o
);

  localparam int unsigned W  = ddo_pkg::FIELD_W;
  localparam int unsigned DW = ddo_pkg::DIFF_W;
  localparam int unsigned NW = ddo_pkg::NUM_W;

  // Item registers.
  logic [W-1:0] ls_q, rs_q, lp_q, rp_q, now_q;
  // Configuration.
  logic [W-1:0] track_width_q, timeout_q;
  // Per-side state.
  logic [1:0]   init_q;
  logic [W-1:0] last_pos_q [2];
  logic [W-1:0] last_time_q [2];
  logic [W-1:0] est_q [2];
  // Quotient results.
  logic [W-1:0] ang_q, head_q, est_ang_q;
  // Divider operands.
  logic [NW-1:0] num_q;
  logic [W-1:0]  den_q;
  logic          neg_q, need_q, out_valid_q;
  logic [ddo_pkg::OUT_DATA_W-1:0] out_data_q;

  logic          side;
  logic          is_side;
  logic [W-1:0]  pos, elapsed, opa, opb;
  logic [DW-1:0] diff, mag;
  logic [NW-1:0] prod, num;
  logic          changed, need;
  logic          div_busy, div_done;
  logic [W-1:0]  quo;
  logic [DW-1:0] lin_sum, dist_sum, est_sum;

  // Operand selection for the current division.
  assign is_side = (cmd_i.op == ddo_pkg::OP_EST_LEFT) || (cmd_i.op == ddo_pkg::OP_EST_RIGHT);
  assign side    = cmd_i.op == ddo_pkg::OP_EST_RIGHT;
  assign pos     = side ? rp_q : lp_q;
  assign elapsed = now_q - last_time_q[side];
  assign changed = pos != last_pos_q[side];
  assign need    = init_q[side] && changed && (elapsed != '0);

  always_comb begin
    case (cmd_i.op)
      ddo_pkg::OP_EST_LEFT,
      ddo_pkg::OP_EST_RIGHT: begin
        opa = last_pos_q[side];
        opb = pos;
      end
      ddo_pkg::OP_ANG_SPEED: begin
        opa = ls_q;
        opb = rs_q;
      end
      ddo_pkg::OP_HEADING: begin
        opa = lp_q;
        opb = rp_q;
      end
      ddo_pkg::OP_EST_ANG: begin
        opa = est_q[0];
        opb = est_q[1];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Signed difference split into sign and magnitude, then scaled.
  assign diff = {opb[W-1], opb} - {opa[W-1], opa};
  assign mag  = diff[DW-1] ? (DW'(0) - diff) : diff;
  assign prod = NW'(mag) * NW'(ddo_pkg::SCALE_US);
  assign num  = is_side ? prod : {(NW - DW - 16)'(0), mag, 16'b0};

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ls_q  <= in_data_i[0*W +: W];
      rs_q  <= in_data_i[1*W +: W];
      lp_q  <= in_data_i[2*W +: W];
      rp_q  <= in_data_i[3*W +: W];
      now_q <= in_data_i[4*W +: W];
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_width_q <= ddo_pkg::TRACK_WIDTH_RST;
      timeout_q     <= ddo_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ddo_pkg::REG_TRACK_WIDTH: track_width_q <= cfg_data_i;
        ddo_pkg::REG_TIMEOUT:     timeout_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Side state: first tick, position change and timeout are settled in the
  // preparation cycle; a new speed estimate lands when its division ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      for (int i = 0; i < 2; i++) begin
        last_pos_q[i]  <= '0;
        last_time_q[i] <= '0;
        est_q[i]       <= '0;
      end
    end else if (cmd_i.prep && is_side) begin
      if (!init_q[side]) begin
        init_q[side]      <= 1'b1;
        last_pos_q[side]  <= pos;
        last_time_q[side] <= now_q;
        est_q[side]       <= '0;
      end else if (changed) begin
        last_pos_q[side]  <= pos;
        last_time_q[side] <= now_q;
      end else if ((timeout_q != '0) && (elapsed > timeout_q)) begin
        est_q[side] <= '0;
      end
    end else if (cmd_i.wb && is_side) begin
      est_q[side] <= quo;
    end
  end

  // Divider operands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 1'b0;
    end else if (cmd_i.prep) begin
      need_q <= is_side ? need : 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      num_q <= num;
      den_q <= is_side ? elapsed : track_width_q;
      neg_q <= diff[DW-1];
    end
  end

  ddo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .neg_i   (neg_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Quotient results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      case (cmd_i.op)
        ddo_pkg::OP_ANG_SPEED: ang_q     <= quo;
        ddo_pkg::OP_HEADING:   head_q    <= quo;
        ddo_pkg::OP_EST_ANG:   est_ang_q <= quo;
        default: ;
      endcase
    end
  end

  // Means are floored halves of exact 33-bit sums.
  assign lin_sum  = {ls_q[W-1], ls_q} + {rs_q[W-1], rs_q};
  assign dist_sum = {lp_q[W-1], lp_q} + {rp_q[W-1], rp_q};
  assign est_sum  = {est_q[0][W-1], est_q[0]} + {est_q[1][W-1], est_q[1]};

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {est_ang_q, est_sum[DW-1:1], head_q, dist_sum[DW-1:1],
                     ang_q, lin_sum[DW-1:1]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    status_o.need_div = need_q;
    status_o.div_busy = div_busy;
    status_o.div_done = div_done;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

>>> src/ddo_ctrl.sv
`default_nettype none

// Sequencer: steps through the five divisions of one item and hands the result over.
module ddo_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ddo_pkg::dp_status_t  status_i,
  output ddo_pkg::ctrl_cmd_t        cmd_o
);

  ddo_pkg::ctrl_state_e state_q, state_d;
  ddo_pkg::op_e         op_q, op_d, op_next;
  logic                 is_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddo_pkg::ST_IDLE;
      op_q    <= ddo_pkg::OP_EST_LEFT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Order of the divisions.
  always_comb begin
    case (op_q)
      ddo_pkg::OP_EST_LEFT:  op_next = ddo_pkg::OP_EST_RIGHT;
      ddo_pkg::OP_EST_RIGHT: op_next = ddo_pkg::OP_ANG_SPEED;
      ddo_pkg::OP_ANG_SPEED: op_next = ddo_pkg::OP_HEADING;
      ddo_pkg::OP_HEADING:   op_next = ddo_pkg::OP_EST_ANG;
      default:               op_next = ddo_pkg::OP_EST_LEFT;
    endcase
  end

  assign is_side = (op_q == ddo_pkg::OP_EST_LEFT) || (op_q == ddo_pkg::OP_EST_RIGHT);

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    in_ready_o       = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.prep       = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.wb         = 1'b0;
    cmd_o.load_out   = 1'b0;
    cmd_o.op         = op_q;
    case (state_q)
      ddo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          op_d         = ddo_pkg::OP_EST_LEFT;
          state_d      = ddo_pkg::ST_PREP;
        end
      end
      ddo_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ddo_pkg::ST_START;
      end
      ddo_pkg::ST_START: begin
        if (is_side && !status_i.need_div) begin
          // No new estimate for this side: move on without dividing.
          op_d    = op_next;
          state_d = ddo_pkg::ST_PREP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ddo_pkg::ST_WAIT;
        end
      end
      ddo_pkg::ST_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.wb = 1'b1;
          if (op_q == ddo_pkg::OP_EST_ANG) begin
            state_d = ddo_pkg::ST_OUT;
          end else begin
            op_d    = op_next;
            state_d = ddo_pkg::ST_PREP;
          end
        end
      end
      ddo_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ddo_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/differential_drive_odometry_top.sv
// Differential-drive odometry in signed Q16.16.
// The input stream carries one tick per transfer: both wheel speeds, both
// wheel positions and a microsecond time. Each tick yields exactly one result
// transfer: linear and angular speed, travelled distance and heading, and the
// mean and angular value of the per-side speed estimates from positions.
// The configuration channel writes the track width (index 0) and the timeout
// (index 1); other indexes are ignored. The user must write them only while
// the block is idle; the block itself does not enforce this.
// One tick is handled at a time. A single restoring divider, one quotient bit
// per cycle, serves all five divisions; a division ends at once when the
// dividend is zero or the quotient reaches 2^32 and saturates, and a side
// with no new estimate skips its division. The next tick is taken in the cycle
// after the result is loaded.
// The result sits in an output register, so a stalled receiver does not stop
// the next tick from being accepted; only the load of the following result
// waits until the register has been drained.
// Reset restores the default configuration and clears all per-side state, so
// the first tick after reset only initialises the estimates to zero.
`default_nettype none

`include "differential_drive_odometry_top_assert.svh"

module differential_drive_odometry_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input ticks.
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // Lowest bit up: left wheel speed, right wheel speed, left wheel position,
  // right wheel position, time in microseconds.
  input  wire logic [ddo_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // Results.
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // Lowest bit up: mean speed, turn rate, distance, heading,
  // estimated mean speed, estimated turn rate.
  output logic [ddo_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o,
  // Configuration writes.
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ddo_pkg::FIELD_W-1:0]        cfg_data_i
);

  ddo_pkg::ctrl_cmd_t  cmd;
  ddo_pkg::dp_status_t status;

  // Configuration writes never wait.
  assign cfg_ready_o = 1'b1;

  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

  // An accepted tick closes the input until its result is loaded.
  `DDO_ASSERT(a_busy_after_accept, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
  // The divider is started only when it is free.
  `DDO_ASSERT(a_div_idle_on_start, cmd.div_start |-> (!status.div_busy && !status.div_done))
  // A result never overwrites one the receiver has not taken.
  `DDO_ASSERT_MSG(a_no_overwrite, cmd.load_out |-> status.out_free, "result overwritten")
  // The output becomes valid only through a load.
  `DDO_ASSERT(a_valid_from_load, $rose(m_axis_tvalid_o) |-> $past(cmd.load_out))

endmodule

`default_nettype wire
